[hdl/rfc_pkg.sv]
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, result codes and the CRC-16 byte step used by the response
// frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [15:0] LIMIT_RESET   = 16'd65529;
    localparam int          QUEUE_DEPTH   = 4;
    localparam int          QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int          QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        RC_OK     = 2'd0,
        RC_CRC    = 2'd1,
        RC_LENGTH = 2'd2,
        RC_STATUS = 2'd3
    } result_code_t;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic         kind;
        logic [7:0]   payload_byte;
        result_code_t result_code;
        logic [7:0]   reader_status;
        logic [15:0]  payload_count;
        logic         last;
    } rfc_result_t;

    // Results written into the output queue in one cycle. Lane 1 is only
    // used when lane 0 is used as well.
    typedef struct packed {
        logic [1:0]  wr_en;
        rfc_result_t lane0;
        rfc_result_t lane1;
    } rfc_push_t;

    // One byte through the reflected CRC-16, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hdl/response_frame_checker_core.sv]
// ----------------------------------------------------------------------------
// response_frame_checker_core
// Byte-serial checker for reader response frames with CRC-16 verification,
// payload forwarding and an end-of-frame verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Frame bytes enter on the input channel (in_valid/in_ready, rx_byte,
//   frame_end), one item per byte, frame_end marking the last byte.
//   Each item yields zero, one or two results on the output channel
//   (out_valid/out_ready): a forwarded payload byte (kind 0) once a byte is
//   known not to belong to the CRC trailer, and at the frame end a verdict
//   (kind 1) with result_code, reader_status and payload_count. The
//   consumer drops forwarded bytes of a frame whose verdict is nonzero.
//   The cfg channel (cfg_valid/cfg_ready, cfg_data) writes payload_limit;
//   it is always ready; the user must write it only while the block is idle (not enforced).
// Timing:
//   An accepted byte is held in the input register, is processed by the
//   CRC step and verdict logic and lands in a four-entry result queue, so
//   its first result is visible once it has passed the input register and
//   been written into the queue. The block takes one byte per cycle as long
//   as the queue has room for two results; the output side delivers one
//   result per cycle while out_ready is high.
// Reset and stall:
//   Reset clears the frame state, empties the queue and sets payload_limit
//   to 65529. When the receiver stalls, the queue fills and in_ready drops;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module response_frame_checker_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  result_code,
    output logic [7:0]  reader_status,
    output logic [15:0] payload_count,
    output logic        last
);

    // Input register: holds one byte until the processing step takes it.
    logic        hold_valid_reg;
    logic [7:0]  hold_byte_reg;
    logic        hold_end_reg;
    logic [15:0] limit_reg;

    logic                 fire;
    logic                 has_room;
    rfc_pkg::rfc_push_t   push;
    rfc_pkg::rfc_result_t head;

    // The held byte is processed when the queue can absorb two results.
    assign fire      = hold_valid_reg && has_room;
    assign in_ready  = !hold_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            limit_reg      <= rfc_pkg::LIMIT_RESET;
        end
        else begin
            if (in_ready) begin
                hold_valid_reg <= in_valid;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            hold_byte_reg <= rx_byte;
            hold_end_reg  <= frame_end;
        end
    end

    rfc_frame_proc u_proc (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cur_byte (hold_byte_reg),
        .cur_end  (hold_end_reg),
        .limit    (limit_reg),
        .push     (push)
    );

    rfc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind          = head.kind;
    assign payload_byte  = head.payload_byte;
    assign result_code   = head.result_code;
    assign reader_status = head.reader_status;
    assign payload_count = head.payload_count;
    assign last          = head.last;

endmodule

[hdl/rfc_frame_proc.sv]
// ----------------------------------------------------------------------------
// rfc_frame_proc
// Frame state and the per-byte work: CRC, delay line, field capture,
// payload forwarding and the end-of-frame verdict.
// ----------------------------------------------------------------------------
module rfc_frame_proc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         cur_byte,
    input  logic               cur_end,
    input  logic [15:0]        limit,
    output rfc_pkg::rfc_push_t push
);

    logic [16:0] idx_reg;
    logic [16:0] idx_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  dly0_reg;
    logic [7:0]  dly1_reg;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [7:0]  status_reg;
    logic [7:0]  status_next;
    logic        ovf_reg;
    logic        ovf_next;

    logic [17:0] n;
    logic [16:0] pay_off;
    logic        fwd;
    rfc_pkg::result_code_t code;
    rfc_pkg::rfc_result_t  fwd_res;
    rfc_pkg::rfc_result_t  verdict;

    always_comb
    begin
        n        = {1'b0, idx_reg} + 18'd1;
        pay_off  = idx_reg - 17'd6;
        crc_next = (idx_reg >= 17'd2) ? rfc_pkg::crc_byte(crc_reg, dly1_reg) : crc_reg;
        fwd      = (idx_reg >= 17'd6) && (pay_off < {1'b0, limit});

        len_next    = len_reg;
        status_next = status_reg;
        if (idx_reg == 17'd1) begin
            len_next = {cur_byte, len_reg[7:0]};
        end
        else if (idx_reg == 17'd2) begin
            len_next = {len_reg[15:8], cur_byte};
        end
        else if (idx_reg == 17'd5) begin
            status_next = cur_byte;
        end

        ovf_next = ovf_reg || (n > ({2'b00, limit} + 18'd6));
        idx_next = (idx_reg == '1) ? idx_reg : idx_reg + 17'd1;

        // Checks in order: short frame, CRC, length, reader status.
        if (n < 18'd6) begin
            code = rfc_pkg::RC_LENGTH;
        end
        else if ({cur_byte, dly0_reg} != crc_next) begin
            code = rfc_pkg::RC_CRC;
        end
        else if (ovf_next || ({2'b00, len_next} != n)) begin
            code = rfc_pkg::RC_LENGTH;
        end
        else if (status_next != 8'd0) begin
            code = rfc_pkg::RC_STATUS;
        end
        else begin
            code = rfc_pkg::RC_OK;
        end

        fwd_res.kind          = rfc_pkg::KIND_DATA;
        fwd_res.payload_byte  = dly1_reg;
        fwd_res.result_code   = rfc_pkg::RC_OK;
        fwd_res.reader_status = 8'd0;
        fwd_res.payload_count = 16'd0;
        fwd_res.last          = !cur_end;

        verdict.kind          = rfc_pkg::KIND_VERDICT;
        verdict.payload_byte  = 8'd0;
        verdict.result_code   = code;
        verdict.reader_status = status_next;
        verdict.payload_count = (code == rfc_pkg::RC_OK) ? n[15:0] - 16'd6 : 16'd0;
        verdict.last          = 1'b1;

        push.lane0    = fwd ? fwd_res : verdict;
        push.lane1    = verdict;
        push.wr_en[0] = fire && (fwd || cur_end);
        push.wr_en[1] = fire && fwd && cur_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg    <= '0;
            crc_reg    <= rfc_pkg::CRC_SEED;
            dly0_reg   <= '0;
            dly1_reg   <= '0;
            len_reg    <= '0;
            status_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (fire) begin
            if (cur_end) begin
                idx_reg    <= '0;
                crc_reg    <= rfc_pkg::CRC_SEED;
                dly0_reg   <= '0;
                dly1_reg   <= '0;
                len_reg    <= '0;
                status_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else begin
                idx_reg    <= idx_next;
                crc_reg    <= crc_next;
                dly0_reg   <= cur_byte;
                dly1_reg   <= dly0_reg;
                len_reg    <= len_next;
                status_reg <= status_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

[hdl/rfc_out_queue.sv]
// ----------------------------------------------------------------------------
// rfc_out_queue
// Small result queue that takes up to two results per cycle and hands out
// one per cycle on the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module rfc_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfc_pkg::rfc_push_t   push,
    output logic                 has_room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rfc_pkg::rfc_result_t head
);

    rfc_pkg::rfc_result_t mem [rfc_pkg::QUEUE_DEPTH];

    logic [rfc_pkg::QUEUE_PTR_W-1:0] wptr_reg;
    logic [rfc_pkg::QUEUE_PTR_W-1:0] wptr_next;
    logic [rfc_pkg::QUEUE_PTR_W-1:0] wptr_plus1;
    logic [rfc_pkg::QUEUE_PTR_W-1:0] rptr_reg;
    logic [rfc_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [rfc_pkg::QUEUE_CNT_W-1:0] count_next;
    logic [rfc_pkg::QUEUE_CNT_W-1:0] push_cnt;
    logic                            pop;

    always_comb
    begin
        pop        = out_valid && out_ready;
        push_cnt   = rfc_pkg::QUEUE_CNT_W'(push.wr_en[0])
                   + rfc_pkg::QUEUE_CNT_W'(push.wr_en[1]);
        wptr_plus1 = wptr_reg + rfc_pkg::QUEUE_PTR_W'(1);
        wptr_next  = wptr_reg + push_cnt[rfc_pkg::QUEUE_PTR_W-1:0];
        count_next = count_reg + push_cnt - rfc_pkg::QUEUE_CNT_W'(pop);
    end

    assign out_valid = (count_reg != '0);
    assign has_room  = (count_reg <= rfc_pkg::QUEUE_CNT_W'(rfc_pkg::QUEUE_DEPTH - 2));
    assign head      = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.wr_en[0]) begin
            mem[wptr_reg] <= push.lane0;
        end
        if (push.wr_en[1]) begin
            mem[wptr_plus1] <= push.lane1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
            if (pop) begin
                rptr_reg <= rptr_reg + rfc_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

endmodule
